### design/decimal_format_streamer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal format streamer
// Each macro checks one implication on the rising edge of clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_FORMAT_STREAMER_ASSERT_SVH
`define DECIMAL_FORMAT_STREAMER_ASSERT_SVH

// Same-cycle implication
`define DFS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decimal_format_streamer: check failed");

// Next-cycle implication
`define DFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decimal_format_streamer: check failed");

`endif

### design/dfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_pkg
// Constants, sequencer states and the BCD digit adjust for the decimal
// format streamer.
// ----------------------------------------------------------------------------
package dfs_pkg;

  // Default sizing
  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS_DEF = 10;

  // Character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_ZERO    = 8'h30;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PCT,
    S_CHAR,
    S_CONV,
    S_SKIP,
    S_EMIT
  } state_t;

  // Double-dabble correction of one BCD digit
  function automatic logic [3:0] add3(input logic [3:0] d);
    logic [3:0] r;
    if (d >= 4'd5) begin
      r = d + 4'd3;
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

### design/decimal_format_streamer.sv
`timescale 1ns / 1ps
// Ordinary byte: the beat is taken in idle, then S_CHAR loads the output register;
//   a byte that resolves a pending percent first passes through S_PCT for the '%'.
// %d pair: the beat is taken in idle, S_CONV shifts in the value bits, then S_SKIP
//   drops leading zeros and S_EMIT emits the digits.
// A new beat is taken only in idle; an output stall holds the emitting states, the last byte may wait.
// Reset clears the sequencer, the pending percent flag and the output valid.
// ----------------------------------------------------------------------------
// decimal_format_streamer
// Streams format characters to ASCII bytes, expanding %d pairs into the
// decimal form of the value, converted one bit per cycle.
// ----------------------------------------------------------------------------
module decimal_format_streamer #(
  parameter int VALUE_BITS = dfs_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = dfs_pkg::MAX_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            format_char,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  string_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  run_last
);

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int REM_W = $clog2(MAX_DIGITS + 1);

  dfs_pkg::state_t state, state_next;

  logic                  pending;
  logic [7:0]            ch_hold;
  logic                  emit_ch;
  logic [VALUE_BITS-1:0] shift_val;
  logic [BCD_W-1:0]      bcd;
  logic                  ovf;
  logic [CNT_W-1:0]      bit_cnt;
  logic [REM_W-1:0]      rem;

  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic [7:0]            out_byte_next;
  logic                  out_last_next;
  logic [BCD_W-1:0]      bcd_adj;
  logic [BCD_W-1:0]      bcd_shifted;
  logic                  bcd_carry;
  logic [3:0]            top_digit;
  logic                  skip_zero;
  logic                  is_pct_hold;

  assign accept      = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign top_digit   = bcd[BCD_W-1 -: 4];
  assign skip_zero   = (top_digit == 4'd0) && (rem > REM_W'(1));
  assign is_pct_hold = (format_char == dfs_pkg::CH_PERCENT) && !string_end;

  // Correct each BCD digit, then shift in the next value bit
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = dfs_pkg::add3(bcd[4*i +: 4]);
    end
  end

  assign bcd_shifted = {bcd_adj[BCD_W-2:0], shift_val[VALUE_BITS-1]};
  assign bcd_carry   = bcd_adj[BCD_W-1];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dfs_pkg::S_IDLE: begin
        if (in_valid) begin
          if (pending && (format_char == dfs_pkg::CH_D)) begin
            state_next = dfs_pkg::S_CONV;
          end else if (pending) begin
            state_next = dfs_pkg::S_PCT;
          end else if (!is_pct_hold) begin
            state_next = dfs_pkg::S_CHAR;
          end
        end
      end
      dfs_pkg::S_PCT: begin
        if (out_free) begin
          state_next = emit_ch ? dfs_pkg::S_CHAR : dfs_pkg::S_IDLE;
        end
      end
      dfs_pkg::S_CHAR: begin
        if (out_free) begin
          state_next = dfs_pkg::S_IDLE;
        end
      end
      dfs_pkg::S_CONV: begin
        if (bit_cnt == CNT_W'(1)) begin
          state_next = dfs_pkg::S_SKIP;
        end
      end
      dfs_pkg::S_SKIP: begin
        if (!skip_zero) begin
          state_next = dfs_pkg::S_EMIT;
        end
      end
      dfs_pkg::S_EMIT: begin
        if (out_free && (rem == REM_W'(1))) begin
          state_next = dfs_pkg::S_IDLE;
        end
      end
      default: state_next = dfs_pkg::S_IDLE;
    endcase
  end

  // Handshake and output register load
  always_comb begin
    in_ready      = 1'b0;
    out_load      = 1'b0;
    out_byte_next = dfs_pkg::CH_PERCENT;
    out_last_next = 1'b0;
    case (state)
      dfs_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      dfs_pkg::S_PCT: begin
        out_load      = out_free;
        out_byte_next = dfs_pkg::CH_PERCENT;
        out_last_next = !emit_ch;
      end
      dfs_pkg::S_CHAR: begin
        out_load      = out_free;
        out_byte_next = ch_hold;
        out_last_next = 1'b1;
      end
      dfs_pkg::S_EMIT: begin
        out_load      = out_free;
        out_byte_next = dfs_pkg::CH_ZERO + {4'd0, top_digit};
        out_last_next = (rem == REM_W'(1));
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dfs_pkg::S_IDLE;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        pending <= is_pct_hold;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath: hold the beat, convert bit by bit, drop and emit digits
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_hold   <= format_char;
      emit_ch   <= !is_pct_hold;
      shift_val <= value;
      bcd       <= '0;
      ovf       <= 1'b0;
      bit_cnt   <= CNT_W'(VALUE_BITS);
    end else begin
      case (state)
        dfs_pkg::S_CONV: begin
          shift_val <= {shift_val[VALUE_BITS-2:0], 1'b0};
          ovf       <= ovf | bcd_carry;
          bit_cnt   <= bit_cnt - CNT_W'(1);
          rem       <= REM_W'(MAX_DIGITS);
          if ((bit_cnt == CNT_W'(1)) && (ovf || bcd_carry)) begin
            bcd <= {MAX_DIGITS{4'd9}};
          end else begin
            bcd <= bcd_shifted;
          end
        end
        dfs_pkg::S_SKIP: begin
          if (skip_zero) begin
            bcd <= {bcd[BCD_W-5:0], 4'd0};
            rem <= rem - REM_W'(1);
          end
        end
        dfs_pkg::S_EMIT: begin
          if (out_free) begin
            bcd <= {bcd[BCD_W-5:0], 4'd0};
            rem <= rem - REM_W'(1);
          end
        end
        default: begin
          rem <= rem;
        end
      endcase
    end
    if (out_load) begin
      out_byte <= out_byte_next;
      run_last <= out_last_next;
    end
  end

  `include "decimal_format_streamer_assert.svh"

  // The closing byte of an item always returns the sequencer to idle
  `DFS_ASSERT_NEXT(a_last_to_idle, out_load && out_last_next, state == dfs_pkg::S_IDLE)
  // Digits are never emitted with an empty digit count
  `DFS_ASSERT_NOW(a_emit_rem, state == dfs_pkg::S_EMIT, rem != '0)
  // Conversion always has bits left to shift
  `DFS_ASSERT_NOW(a_conv_cnt, state == dfs_pkg::S_CONV, bit_cnt != '0)
  // A string end never leaves a percent pending
  `DFS_ASSERT_NEXT(a_end_clears, accept && string_end, !pending)

endmodule
